/* design/infix_to_postfix_converter_defines.svh */
// ----------------------------------------------------------------------------
// Infix to postfix converter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Check a condition at every clock edge
`define I2P_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define I2P_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define I2P_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter: package
// Character codes, stack codes, item types and classification helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Operator stack sizing
  localparam int STACK_DEPTH = 32;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int SP_W        = $clog2(STACK_DEPTH);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII characters for operators, parentheses and the terminator
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_TERM  = 8'h00;

  // Fault codes carried on each result item
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd1;
  localparam logic [1:0] FAULT_PAREN    = 2'd2;

  // Stack entry codes; bit 1 gives the rank of an arithmetic operator
  typedef enum logic [2:0] {
    CODE_PLUS  = 3'd0,
    CODE_MINUS = 3'd1,
    CODE_MUL   = 3'd2,
    CODE_DIV   = 3'd3,
    CODE_OPEN  = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    KIND_OPERAND,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER
  } sym_kind_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eoe;
    sym_kind_t  kind;
    op_code_t   code;
  } q_item_t;

  typedef enum logic {
    BK_MAIN,
    BK_FLUSH
  } back_state_t;

  function automatic sym_kind_t classify_kind(input logic [7:0] ch);
    sym_kind_t k;
    unique case (ch)
      CH_PLUS, CH_MINUS, CH_MUL, CH_DIV: k = KIND_OPER;
      CH_OPEN:                           k = KIND_OPEN;
      CH_CLOSE:                          k = KIND_CLOSE;
      default:                           k = KIND_OPERAND;
    endcase
    return k;
  endfunction

  function automatic op_code_t classify_code(input logic [7:0] ch);
    op_code_t c;
    unique case (ch)
      CH_PLUS:  c = CODE_PLUS;
      CH_MINUS: c = CODE_MINUS;
      CH_MUL:   c = CODE_MUL;
      CH_DIV:   c = CODE_DIV;
      default:  c = CODE_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t c);
    logic [7:0] ch;
    unique case (c)
      CODE_PLUS:  ch = CH_PLUS;
      CODE_MINUS: ch = CH_MINUS;
      CODE_MUL:   ch = CH_MUL;
      CODE_DIV:   ch = CH_DIV;
      default:    ch = CH_OPEN;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* design/i2p_if.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter: channel interfaces
// Valid/ready channels for input characters, classified items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_in;
  logic       end_of_expr;

  modport source (output valid, output symbol_in, output end_of_expr, input ready);
  modport sink   (input valid, input symbol_in, input end_of_expr, output ready);
endinterface

interface i2p_item_if;
  import i2p_pkg::*;
  logic    valid;
  logic    ready;
  q_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic       is_last;
  logic [1:0] fault;

  modport source (output valid, output symbol_out, output is_last, output fault, input ready);
  modport sink   (input valid, input symbol_out, input is_last, input fault, output ready);
endinterface

`default_nettype wire

/* design/i2p_queue.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter: item queue
// Short FIFO that decouples the classifying front from the stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module i2p_queue (
  input  wire logic clk,
  input  wire logic rst,
  i2p_item_if.sink   src,
  i2p_item_if.source dst
);
  import i2p_pkg::*;

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // Handshake on both sides
  assign src.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign dst.valid = (count != '0);
  assign dst.item  = slots[rd_ptr];
  assign push      = src.valid && src.ready;
  assign pop       = dst.valid && dst.ready;

  // Store an incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= src.item;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `I2P_ASSERT_ALWAYS(a_q_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `I2P_ASSERT_NEXT(a_q_count_inc, push && !pop, count == $past(count) + 1'b1, "queue count slip")

endmodule

`default_nettype wire

/* design/i2p_front.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter: front end
// Accepts characters, classifies them and registers one item for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2p_front (
  input  wire logic clk,
  input  wire logic rst,
  i2p_in_if.sink     symbols,
  i2p_item_if.source items
);
  import i2p_pkg::*;

  logic    hold_valid;
  q_item_t hold_item;
  logic    take;

  assign symbols.ready = !hold_valid || items.ready;
  assign take          = symbols.valid && symbols.ready;
  assign items.valid   = hold_valid;
  assign items.item    = hold_item;

  // Classify and hold the accepted item
  always_ff @(posedge clk) begin
    if (take) begin
      hold_item.symbol <= symbols.symbol_in;
      hold_item.eoe    <= symbols.end_of_expr;
      hold_item.kind   <= classify_kind(symbols.symbol_in);
      hold_item.code   <= classify_code(symbols.symbol_in);
    end
  end

  // Track the holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (items.ready) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/i2p_back.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter: stack engine
// Steps the stack once a cycle unless output stalls; registers result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module i2p_back (
  input  wire logic clk,
  input  wire logic rst,
  i2p_item_if.sink  items,
  i2p_out_if.source postfix
);
  import i2p_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  op_code_t          stack [STACK_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_m1;
  logic [1:0]        pending_fault;

  logic              out_valid;
  logic [7:0]        out_sym;
  logic              out_last;
  logic [1:0]        out_fault;

  q_item_t           head;
  op_code_t          top;
  logic              not_empty;
  logic              full;
  logic              out_free;

  logic              emit;
  logic [7:0]        emit_sym;
  logic              emit_last;
  logic              do_push;
  op_code_t          push_code;
  logic              do_pop;
  logic              set_fault;
  logic [1:0]        fault_val;
  logic              step_done;
  logic              flush_done;
  logic              push_ok;

  assign head      = items.item;
  assign fill_m1   = fill - 1'b1;
  assign top       = stack[fill_m1[SP_W-1:0]];
  assign not_empty = (fill != '0);
  assign full      = (fill == FILL_W'(STACK_DEPTH));
  assign out_free  = !out_valid || postfix.ready;
  assign push_ok   = do_push && !full;

  assign items.ready        = step_done;
  assign postfix.valid      = out_valid;
  assign postfix.symbol_out = out_sym;
  assign postfix.is_last    = out_last;
  assign postfix.fault      = out_fault;

  // Choose the step for this cycle
  always_comb begin
    emit       = 1'b0;
    emit_sym   = head.symbol;
    emit_last  = 1'b0;
    do_push    = 1'b0;
    push_code  = head.code;
    do_pop     = 1'b0;
    set_fault  = 1'b0;
    fault_val  = FAULT_NONE;
    step_done  = 1'b0;
    flush_done = 1'b0;
    unique case (state)
      BK_MAIN: begin
        if (items.valid) begin
          unique case (head.kind)
            KIND_OPERAND: begin
              if (out_free) begin
                emit      = 1'b1;
                step_done = 1'b1;
              end
            end
            KIND_OPEN: begin
              do_push   = 1'b1;
              push_code = CODE_OPEN;
              step_done = 1'b1;
            end
            KIND_CLOSE: begin
              if (not_empty && top != CODE_OPEN) begin
                if (out_free) begin
                  emit     = 1'b1;
                  emit_sym = op_char(top);
                  do_pop   = 1'b1;
                end
              end else if (not_empty) begin
                do_pop    = 1'b1;
                step_done = 1'b1;
              end else begin
                set_fault = 1'b1;
                fault_val = FAULT_PAREN;
                step_done = 1'b1;
              end
            end
            KIND_OPER: begin
              if (not_empty && top != CODE_OPEN && top[1] >= head.code[1]) begin
                if (out_free) begin
                  emit     = 1'b1;
                  emit_sym = op_char(top);
                  do_pop   = 1'b1;
                end
              end else begin
                do_push   = 1'b1;
                step_done = 1'b1;
              end
            end
            default: begin
              step_done = 1'b1;
            end
          endcase
        end
      end
      BK_FLUSH: begin
        if (not_empty) begin
          if (top == CODE_OPEN) begin
            do_pop    = 1'b1;
            set_fault = 1'b1;
            fault_val = FAULT_PAREN;
          end else if (out_free) begin
            emit     = 1'b1;
            emit_sym = op_char(top);
            do_pop   = 1'b1;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          emit_sym   = CH_TERM;
          emit_last  = 1'b1;
          flush_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (do_push && full) begin
      set_fault = 1'b1;
      fault_val = FAULT_OVERFLOW;
    end
  end

  // Enter the flush after a final character; leave it after the terminator
  always_comb begin
    state_next = state;
    unique case (state)
      BK_MAIN: begin
        if (step_done && head.eoe) begin
          state_next = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (flush_done) begin
          state_next = BK_MAIN;
        end
      end
      default: begin
        state_next = BK_MAIN;
      end
    endcase
  end

  // Write the stack top on a push
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack[fill[SP_W-1:0]] <= push_code;
    end
  end

  // Hold a result item until it is taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_sym   <= emit_sym;
      out_last  <= emit_last;
      out_fault <= pending_fault;
    end
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_MAIN;
      fill          <= '0;
      pending_fault <= FAULT_NONE;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (push_ok) begin
        fill <= fill + 1'b1;
      end else if (do_pop) begin
        fill <= fill_m1;
      end
      if (set_fault) begin
        pending_fault <= fault_val;
      end else if (emit) begin
        pending_fault <= FAULT_NONE;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (postfix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `I2P_ASSERT_ALWAYS(a_fill_bound, fill <= FILL_W'(STACK_DEPTH), "stack fill overrun")
  `I2P_ASSERT_IMPLY(a_pop_nonempty, do_pop, not_empty, "pop from empty stack")
  `I2P_ASSERT_NEXT(a_term_clears_fault, emit && emit_last, pending_fault == FAULT_NONE, "fault kept past terminator")

endmodule

`default_nettype wire

/* design/infix_to_postfix_converter.sv */
// Path: a character is registered in the front holding stage, then in a queue slot,
// then in the output register. The stack engine emits an operand and pushes '('
// directly; an operator or ')' first pops and emits stacked operators one at a time,
// and an end flag then empties the stack and emits the terminator before a new item.
// Reset: clears stack fill, pending fault, queue and output valid; stack entries are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Infix to postfix converter: top level
// Front classifier, item queue and operator stack engine in a row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic clk,
  input  wire logic rst,
  i2p_in_if.sink    symbols,
  i2p_out_if.source postfix
);

  i2p_item_if front_items ();
  i2p_item_if back_items ();

  // Classify incoming characters
  i2p_front u_front (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .items   (front_items)
  );

  // Buffer classified items
  i2p_queue u_queue (
    .clk (clk),
    .rst (rst),
    .src (front_items),
    .dst (back_items)
  );

  // Run the operator stack
  i2p_back u_back (
    .clk     (clk),
    .rst     (rst),
    .items   (back_items),
    .postfix (postfix)
  );

endmodule

`default_nettype wire
